FILE: rtl/core/wmbt_pkg.sv
// ----------------------------------------------------------------------------
// wmbt_pkg
// Shared constants, command codes and status types of the weighted material
// blend table.
// ----------------------------------------------------------------------------
package wmbt_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;

    localparam int ID_W   = 16;
    localparam int WT_W   = 20;
    localparam int Q_W    = 17;
    localparam int MODE_W = 3;
    localparam int OP_W   = 2;
    localparam int PROD_W = WT_W + Q_W + 1;
    localparam int DIVD_W = WT_W + 16 + 1;

    localparam logic [Q_W-1:0]  ONE_Q16    = 17'h10000;
    localparam logic [WT_W-1:0] WEIGHT_MAX = 20'hFFFFF;

    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPLY  = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    localparam logic [MODE_W-1:0] MODE_ADD      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REPLACE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MULTIPLY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MIN      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MAX      = 3'd5;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CLR,
        CMD_SCALE_MUL,
        CMD_SCALE_WR,
        CMD_SEARCH,
        CMD_MUL1,
        CMD_MUL2,
        CMD_ADJUST,
        CMD_SUM,
        CMD_EMPTY,
        CMD_DIV_START,
        CMD_DIV_WR,
        CMD_SORT_LOAD,
        CMD_SORT_CMP,
        CMD_SORT_WR,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [MODE_W-1:0] mode;
        logic              t_zero;
        logic              idx_end;
        logic              idx_last;
        logic              l_end;
        logic              sum_zero;
        logic              div_done;
    } stat_t;

endpackage

FILE: rtl/core/wmbt_div.sv
// ----------------------------------------------------------------------------
// wmbt_div
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
// ----------------------------------------------------------------------------
module wmbt_div #(
    parameter int SW = 23
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wmbt_pkg::DIVD_W-1:0] dividend,
    input  logic [SW-1:0]               divisor,
    output logic                        done,
    output logic [wmbt_pkg::Q_W-1:0]    quotient
);
    import wmbt_pkg::*;

    localparam int CNT_W = $clog2(Q_W + 1);
    localparam int HI_W  = DIVD_W - Q_W;

    logic [SW:0]      rem_reg;
    logic [Q_W-1:0]   lo_reg;
    logic [Q_W-1:0]   q_reg;
    logic [SW-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [SW:0]      trial;
    logic             ge;

    assign trial = {rem_reg[SW-1:0], lo_reg[Q_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(Q_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {{(SW + 1 - HI_W){1'b0}}, dividend[DIVD_W-1:Q_W]};
            lo_reg  <= dividend[Q_W-1:0];
            dvs_reg <= divisor;
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? (trial - {1'b0, dvs_reg}) : trial;
            lo_reg  <= {lo_reg[Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[Q_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: rtl/core/wmbt_ctrl.sv
// ----------------------------------------------------------------------------
// wmbt_ctrl
// Sequencer: walks the datapath through start, apply, finish and emit phases.
// ----------------------------------------------------------------------------
module wmbt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  wmbt_pkg::stat_t stat,
    output wmbt_pkg::cmd_t  cmd,
    output logic            busy
);
    import wmbt_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_DISPATCH  = 15'b000000000000010,
        S_SCALE_MUL = 15'b000000000000100,
        S_SCALE_WR  = 15'b000000000001000,
        S_SEARCH    = 15'b000000000010000,
        S_MUL1      = 15'b000000000100000,
        S_MUL2      = 15'b000000001000000,
        S_ADJUST    = 15'b000000010000000,
        S_SUM       = 15'b000000100000000,
        S_EMPTY     = 15'b000001000000000,
        S_DIV       = 15'b000010000000000,
        S_DIV_WAIT  = 15'b000100000000000,
        S_SORT_L    = 15'b001000000000000,
        S_SORT_R    = 15'b010000000000000,
        S_EMIT      = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = CMD_NONE;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_APPLY:
                    begin
                        if (stat.t_zero || (stat.mode > MODE_MAX))
                            state_next = S_IDLE;
                        else if (stat.mode == MODE_REPLACE)
                            state_next = S_SCALE_MUL;
                        else
                            state_next = S_SEARCH;
                    end
                    OP_FINISH: state_next = S_SUM;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_SCALE_MUL:
            begin
                if (stat.idx_end)
                begin
                    cmd        = CMD_CLR;
                    state_next = S_SEARCH;
                end
                else
                begin
                    cmd        = CMD_SCALE_MUL;
                    state_next = S_SCALE_WR;
                end
            end
            S_SCALE_WR:
            begin
                cmd        = CMD_SCALE_WR;
                state_next = S_SCALE_MUL;
            end
            S_SEARCH:
            begin
                if (stat.idx_end)
                    state_next = S_MUL1;
                else
                    cmd = CMD_SEARCH;
            end
            S_MUL1:
            begin
                cmd        = CMD_MUL1;
                state_next = (stat.mode == MODE_MULTIPLY) ? S_MUL2 : S_ADJUST;
            end
            S_MUL2:
            begin
                cmd        = CMD_MUL2;
                state_next = S_ADJUST;
            end
            S_ADJUST:
            begin
                cmd        = CMD_ADJUST;
                state_next = S_IDLE;
            end
            S_SUM:
            begin
                if (stat.idx_end)
                begin
                    cmd        = CMD_CLR;
                    state_next = stat.sum_zero ? S_EMPTY : S_DIV;
                end
                else
                    cmd = CMD_SUM;
            end
            S_EMPTY:
            begin
                cmd        = CMD_EMPTY;
                state_next = S_IDLE;
            end
            S_DIV:
            begin
                if (stat.idx_end)
                begin
                    cmd        = CMD_CLR;
                    state_next = S_SORT_L;
                end
                else
                begin
                    cmd        = CMD_DIV_START;
                    state_next = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd        = CMD_DIV_WR;
                    state_next = S_DIV;
                end
            end
            S_SORT_L:
            begin
                if (stat.l_end)
                begin
                    cmd        = CMD_CLR;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd        = CMD_SORT_LOAD;
                    state_next = S_SORT_R;
                end
            end
            S_SORT_R:
            begin
                if (stat.idx_end)
                begin
                    cmd        = CMD_SORT_WR;
                    state_next = S_SORT_L;
                end
                else
                    cmd = CMD_SORT_CMP;
            end
            S_EMIT:
            begin
                cmd = CMD_EMIT;
                if (stat.idx_last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: rtl/core/wmbt_dp.sv
// ----------------------------------------------------------------------------
// wmbt_dp
// Datapath: entry table, shared Q.16 multiplier, weight sum, divider,
// exchange sort with a held entry, and the result registers.
// ----------------------------------------------------------------------------
module wmbt_dp #(
    parameter int TABLE_ENTRIES = wmbt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wmbt_pkg::cmd_t              cmd,
    input  logic [wmbt_pkg::OP_W-1:0]   operation,
    input  logic [wmbt_pkg::ID_W-1:0]   material_id,
    input  logic [wmbt_pkg::Q_W-1:0]    authored_weight,
    input  logic [wmbt_pkg::MODE_W-1:0] blend_mode,
    input  logic [wmbt_pkg::Q_W-1:0]    influence,
    output wmbt_pkg::stat_t             stat,
    output logic                        valid,
    output logic [wmbt_pkg::ID_W-1:0]   entry_material,
    output logic [wmbt_pkg::Q_W-1:0]    entry_weight,
    output logic                        entry_last,
    output logic                        table_empty
);
    import wmbt_pkg::*;

    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int SW = WT_W + $clog2(TABLE_ENTRIES);
    localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

    logic [ID_W-1:0]   ids_reg [TABLE_ENTRIES];
    logic [WT_W-1:0]   wts_reg [TABLE_ENTRIES];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     lidx_reg;
    logic [OP_W-1:0]   op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [Q_W-1:0]    a_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [Q_W-1:0]    t_reg;
    logic [WT_W-1:0]   c_reg;
    logic              found_reg;
    logic [IW-1:0]     fidx_reg;
    logic [IW-1:0]     widx_reg;
    logic [WT_W-1:0]   wweak_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SW-1:0]     sum_reg;
    logic [WT_W-1:0]   hold_w_reg;
    logic [ID_W-1:0]   hold_id_reg;
    logic              valid_reg;
    logic [ID_W-1:0]   mat_reg;
    logic [Q_W-1:0]    wout_reg;
    logic              last_reg;
    logic              empty_reg;

    logic [IW-1:0]     rd_addr;
    logic [WT_W-1:0]   rd_w;
    logic [ID_W-1:0]   rd_id;
    logic [WT_W-1:0]   mul_x;
    logic [Q_W-1:0]    mul_y;
    logic [WT_W-1:0]   rnd;
    logic [WT_W-1:0]   a_ext;
    logic [WT_W-1:0]   mag;
    logic              neg;
    logic [WT_W:0]     add_sum;
    logic [WT_W-1:0]   pos_w;
    logic [WT_W-1:0]   neg_w;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [WT_W-1:0]   wr_w;
    logic [ID_W-1:0]   wr_id;
    logic              append;
    logic              heavier;
    logic              div_done;
    logic [Q_W-1:0]    quot;
    logic [DIVD_W-1:0] dividend;

    assign rd_addr = (cmd == CMD_SORT_LOAD) ? lidx_reg[IW-1:0] : idx_reg[IW-1:0];
    assign rd_w    = wts_reg[rd_addr];
    assign rd_id   = ids_reg[rd_addr];
    assign rnd     = prod_reg[WT_W+15:16];
    assign a_ext   = WT_W'(a_reg);
    assign heavier = rd_w > hold_w_reg;

    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        case (cmd)
            CMD_SCALE_MUL:
            begin
                mul_x = rd_w;
                mul_y = ONE_Q16 - t_reg;
            end
            CMD_MUL1:
            begin
                mul_y = t_reg;
                case (mode_reg)
                    MODE_MULTIPLY: mul_x = WT_W'(ONE_Q16 - a_reg);
                    MODE_MIN:      mul_x = (a_ext < c_reg) ? (c_reg - a_ext) : '0;
                    MODE_MAX:      mul_x = (a_ext > c_reg) ? (a_ext - c_reg) : '0;
                    default:       mul_x = a_ext;
                endcase
            end
            CMD_MUL2:
            begin
                mul_x = c_reg;
                mul_y = ONE_Q16 - rnd[Q_W-1:0];
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    always_comb
    begin
        mag = rnd;
        neg = 1'b0;
        case (mode_reg)
            MODE_SUB, MODE_MIN: neg = 1'b1;
            MODE_MULTIPLY:
            begin
                mag = c_reg - rnd;
                neg = 1'b1;
            end
            default: neg = 1'b0;
        endcase
    end

    assign add_sum = {1'b0, c_reg} + {1'b0, mag};
    assign pos_w   = add_sum[WT_W] ? WEIGHT_MAX : add_sum[WT_W-1:0];
    assign neg_w   = (c_reg >= mag) ? (c_reg - mag) : '0;
    assign append  = (id_reg != '0) && (mag != '0) && !found_reg && !neg
                     && (count_reg < FULL);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[IW-1:0];
        wr_w    = rd_w;
        wr_id   = rd_id;
        case (cmd)
            CMD_LOAD:
            begin
                wr_en   = (operation == OP_START) && (material_id != '0);
                wr_addr = '0;
                wr_w    = WT_W'(ONE_Q16);
                wr_id   = material_id;
            end
            CMD_SCALE_WR:
            begin
                wr_en = 1'b1;
                wr_w  = rnd;
            end
            CMD_ADJUST:
            begin
                wr_id = id_reg;
                if ((id_reg != '0) && (mag != '0))
                begin
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = fidx_reg;
                        wr_w    = neg ? neg_w : pos_w;
                    end
                    else if (!neg)
                    begin
                        wr_w = mag;
                        if (count_reg < FULL)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = count_reg[IW-1:0];
                        end
                        else if (mag > wweak_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = widx_reg;
                        end
                    end
                end
            end
            CMD_DIV_WR:
            begin
                wr_en = 1'b1;
                wr_w  = WT_W'(quot);
            end
            CMD_SORT_CMP:
            begin
                wr_en = heavier;
                wr_w  = hold_w_reg;
                wr_id = hold_id_reg;
            end
            CMD_SORT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = lidx_reg[IW-1:0];
                wr_w    = hold_w_reg;
                wr_id   = hold_id_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ids_reg[wr_addr] <= wr_id;
            wts_reg[wr_addr] <= wr_w;
        end
    end

    assign dividend = DIVD_W'({rd_w, 16'h0000}) + DIVD_W'(sum_reg >> 1);

    wmbt_div #(
        .SW (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd == CMD_DIV_START),
        .dividend (dividend),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            lidx_reg  <= '0;
            op_reg    <= OP_START;
            mode_reg  <= MODE_ADD;
            t_reg     <= '0;
            found_reg <= 1'b0;
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            case (cmd)
                CMD_LOAD:
                begin
                    op_reg    <= operation;
                    mode_reg  <= blend_mode;
                    t_reg     <= (influence > ONE_Q16) ? ONE_Q16 : influence;
                    idx_reg   <= '0;
                    lidx_reg  <= '0;
                    found_reg <= 1'b0;
                    sum_reg   <= '0;
                    if (operation == OP_START)
                        count_reg <= (material_id != '0) ? CW'(1) : '0;
                end
                CMD_CLR:
                begin
                    idx_reg   <= '0;
                    lidx_reg  <= '0;
                    found_reg <= 1'b0;
                end
                CMD_SCALE_WR, CMD_DIV_WR, CMD_SORT_CMP:
                    idx_reg <= idx_reg + 1'b1;
                CMD_SEARCH:
                begin
                    if ((rd_id == id_reg) && !found_reg)
                        found_reg <= 1'b1;
                    idx_reg <= idx_reg + 1'b1;
                end
                CMD_ADJUST:
                begin
                    if (append)
                        count_reg <= count_reg + 1'b1;
                end
                CMD_SUM:
                begin
                    sum_reg <= sum_reg + SW'(rd_w);
                    idx_reg <= idx_reg + 1'b1;
                end
                CMD_EMPTY:
                begin
                    count_reg <= '0;
                    valid_reg <= 1'b1;
                end
                CMD_SORT_LOAD:
                    idx_reg <= lidx_reg + 1'b1;
                CMD_SORT_WR:
                    lidx_reg <= lidx_reg + 1'b1;
                CMD_EMIT:
                begin
                    valid_reg <= 1'b1;
                    idx_reg   <= idx_reg + 1'b1;
                end
                default:
                    idx_reg <= idx_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                id_reg    <= material_id;
                a_reg     <= (authored_weight > ONE_Q16) ? ONE_Q16 : authored_weight;
                c_reg     <= '0;
                fidx_reg  <= '0;
                widx_reg  <= '0;
                wweak_reg <= WEIGHT_MAX;
            end
            CMD_CLR:
            begin
                c_reg     <= '0;
                widx_reg  <= '0;
                wweak_reg <= WEIGHT_MAX;
            end
            CMD_SCALE_MUL, CMD_MUL1, CMD_MUL2:
                prod_reg <= PROD_W'(mul_x) * PROD_W'(mul_y) + PROD_W'(32768);
            CMD_SEARCH:
            begin
                if ((rd_id == id_reg) && !found_reg)
                begin
                    fidx_reg <= idx_reg[IW-1:0];
                    c_reg    <= rd_w;
                end
                if (rd_w < wweak_reg)
                begin
                    widx_reg  <= idx_reg[IW-1:0];
                    wweak_reg <= rd_w;
                end
            end
            CMD_EMPTY:
            begin
                mat_reg   <= '0;
                wout_reg  <= '0;
                last_reg  <= 1'b1;
                empty_reg <= 1'b1;
            end
            CMD_SORT_LOAD:
            begin
                hold_w_reg  <= rd_w;
                hold_id_reg <= rd_id;
            end
            CMD_SORT_CMP:
            begin
                if (heavier)
                begin
                    hold_w_reg  <= rd_w;
                    hold_id_reg <= rd_id;
                end
            end
            CMD_EMIT:
            begin
                mat_reg   <= rd_id;
                wout_reg  <= rd_w[Q_W-1:0];
                last_reg  <= stat.idx_last;
                empty_reg <= 1'b0;
            end
            default:
                prod_reg <= prod_reg;
        endcase
    end

    assign stat.op       = op_reg;
    assign stat.mode     = mode_reg;
    assign stat.t_zero   = (t_reg == '0);
    assign stat.idx_end  = (idx_reg == count_reg);
    assign stat.idx_last = (idx_reg == CW'(count_reg - 1'b1));
    assign stat.l_end    = (lidx_reg == count_reg);
    assign stat.sum_zero = (sum_reg == '0);
    assign stat.div_done = div_done;

    assign valid          = valid_reg;
    assign entry_material = mat_reg;
    assign entry_weight   = wout_reg;
    assign entry_last     = last_reg;
    assign table_empty    = empty_reg;

endmodule

FILE: rtl/core/weighted_material_blend_table_top.sv
// ----------------------------------------------------------------------------
// weighted_material_blend_table_top
// Table of (material, weight) entries: start seeds, apply blends one
// material, finish normalizes, sorts descending and emits the entries.
//
//   channel   handshake            payload
//   item in   start / busy         operation, material_id, authored_weight,
//                                  blend_mode, influence
//   result    valid (per result)   entry_material, entry_weight, entry_last,
//                                  table_empty
//
// An item is taken when start is high and busy low; busy stays high until
// the item is finished. Apply with replace first rescales every entry
// through the one multiplier; multiply adds a second multiplier step.
// Finish sums the weights, divides each entry (17-step divider, started
// and written back per entry), runs an exchange sort (one table read per
// cycle) and emits one result a cycle; a zero sum emits a single empty
// result instead.
// Reset clears the entry count; results cannot be stalled.
// ----------------------------------------------------------------------------
module weighted_material_blend_table_top #(
    parameter int TABLE_ENTRIES = wmbt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [wmbt_pkg::OP_W-1:0]   operation,
    input  logic [wmbt_pkg::ID_W-1:0]   material_id,
    input  logic [wmbt_pkg::Q_W-1:0]    authored_weight,
    input  logic [wmbt_pkg::MODE_W-1:0] blend_mode,
    input  logic [wmbt_pkg::Q_W-1:0]    influence,
    output logic                        valid,
    output logic [wmbt_pkg::ID_W-1:0]   entry_material,
    output logic [wmbt_pkg::Q_W-1:0]    entry_weight,
    output logic                        entry_last,
    output logic                        table_empty
);
    import wmbt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    wmbt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    wmbt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .operation       (operation),
        .material_id     (material_id),
        .authored_weight (authored_weight),
        .blend_mode      (blend_mode),
        .influence       (influence),
        .stat            (stat),
        .valid           (valid),
        .entry_material  (entry_material),
        .entry_weight    (entry_weight),
        .entry_last      (entry_last),
        .table_empty     (table_empty)
    );

`ifndef SYNTHESIS
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        valid && entry_last |=> !valid)
        else $error("result after last item of a run");

    a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !entry_last |-> busy)
        else $error("run ended before last result");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        valid && table_empty |-> entry_last && (entry_weight == '0))
        else $error("malformed empty result");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");
`endif

endmodule
